// ===== hdl/asc_pkg.sv =====
// asc_pkg: shared types and codes for the arming sequence controller.
// No dependencies; imported by every module under hdl/.
package asc_pkg;

  localparam int unsigned TimeW = 63;
  localparam int unsigned DurW  = 32;

  typedef enum logic [1:0] {
    ACT_DISARM = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    PH_DISARMED       = 3'd0,
    PH_ARM_PENDING    = 3'd1,
    PH_ARMING         = 3'd2,
    PH_ARMED          = 3'd3,
    PH_DISARM_PENDING = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DISARM   = 3'd1,
    EV_REJECT   = 3'd2,
    EV_BEGIN    = 3'd3,
    EV_COMPLETE = 3'd4
  } event_t;

  typedef struct packed {
    logic [1:0]       action;
    logic             force_arm;
    logic             pos_fix;
    logic [TimeW-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] event_code;
    logic [2:0] phase_now;
  } result_t;

endpackage

// ===== hdl/asc_in_stage.sv =====
// asc_in_stage: input word register with valid/stall handshake.
// Depends on asc_pkg (item_t).
module asc_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  asc_pkg::item_t item_in,
  input  logic          advance,   // downstream takes the held word this cycle
  output logic          held_valid,
  output asc_pkg::item_t held_item
);
  import asc_pkg::*;

  logic take;

  // hold off only when a word sits here and cannot move on
  assign item_stall = held_valid && !advance;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= take || (held_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item <= item_in;
    end
  end

endmodule

// ===== hdl/asc_core.sv =====
// asc_core: phase state machine, deadline and force latch, arming duration register.
// Depends on asc_pkg (phase/event/action codes, item_t, result_t).
module asc_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,        // apply held word this cycle
  input  asc_pkg::item_t            item,
  input  logic                      cfg_wr_en,
  input  logic [asc_pkg::DurW-1:0]  cfg_wr_data,
  output asc_pkg::result_t          result
);
  import asc_pkg::*;

  phase_t           phase, phase_next;
  logic [TimeW-1:0] deadline, deadline_next;
  logic             force_latched, force_latched_next;
  logic [DurW-1:0]  arming_duration;

  logic [TimeW:0]   sum;
  logic [TimeW-1:0] sum_sat;
  logic             accepted;
  event_t           ev;

  // deadline sum, saturating at the top of the time range
  assign sum     = {1'b0, item.now_time} + {{(TimeW + 1 - DurW){1'b0}}, arming_duration};
  assign sum_sat = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      arming_duration <= '0;
    end else if (cfg_wr_en) begin
      arming_duration <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DISARMED;
      deadline      <= '0;
      force_latched <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      deadline      <= deadline_next;
      force_latched <= force_latched_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    deadline_next      = deadline;
    force_latched_next = force_latched;
    accepted           = 1'b0;
    ev                 = EV_NONE;
    case (item.action)
      ACT_DISARM: begin
        phase_next         = PH_DISARM_PENDING;
        deadline_next      = '0;
        force_latched_next = 1'b0;
        accepted           = 1'b1;
      end
      ACT_ARM: begin
        if (phase == PH_DISARMED) begin
          phase_next         = PH_ARM_PENDING;
          force_latched_next = item.force_arm;
          accepted           = 1'b1;
        end
      end
      ACT_TICK: begin
        case (phase)
          PH_DISARM_PENDING: begin
            phase_next    = PH_DISARMED;
            deadline_next = '0;
            ev            = EV_DISARM;
          end
          PH_ARM_PENDING: begin
            if (!force_latched && !item.pos_fix) begin
              phase_next = PH_DISARMED;
              ev         = EV_REJECT;
            end else begin
              phase_next    = PH_ARMING;
              deadline_next = sum_sat;
              ev            = EV_BEGIN;
            end
          end
          PH_ARMING: begin
            if (item.now_time >= deadline) begin
              phase_next    = PH_ARMED;
              deadline_next = '0;
              ev            = EV_COMPLETE;
            end
          end
          default: begin
            ev = EV_NONE;
          end
        endcase
      end
      default: begin
        // unused action code: report phase, change nothing
        accepted = 1'b0;
      end
    endcase
  end

  assign result.accepted   = accepted;
  assign result.event_code = ev;
  assign result.phase_now  = phase_next;

endmodule

// ===== hdl/asc_out_stage.sv =====
// asc_out_stage: result word register with valid/stall handshake.
// Depends on asc_pkg (result_t).
module asc_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,  // a word is offered from the core
  input  asc_pkg::result_t load_result,
  output logic             free,        // register can take a word this cycle
  output logic             result_valid,
  input  logic             result_stall,
  output asc_pkg::result_t held_result
);
  import asc_pkg::*;

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load_valid) begin
      held_result <= load_result;
    end
  end

endmodule

// ===== hdl/arming_sequence_controller.sv =====
// Arming sequence controller: five-phase arm/disarm state machine.
// Depends on asc_pkg, asc_in_stage, asc_core, asc_out_stage.
//
// Usage
//   Input channel (item_valid / item_stall) carries one word per request or
//   tick: action (0 disarm, 1 arm, 2 tick), force_arm, pos_fix, now_time.
//   Output channel (result_valid / result_stall) returns exactly one word per
//   input word: accepted, event_code, phase_now.
//   cfg_wr_en / cfg_wr_data write the 32-bit arming duration (us); write only
//   while no word is in flight.
// Timing
//   A word accepted from the input channel sits in the input register, is applied to the
//   state on the edge that the result register takes it, and shows on the output from that edge.
//   One word per cycle sustained while result_stall is low; the path between the registers is the
//   63-bit deadline add in parallel with the 63-bit deadline compare.
// Reset (rst, synchronous): phase disarmed, deadline and force latch cleared,
//   arming duration 0, both channels empty.
// Stall: while result_stall holds a valid result, the input register keeps
//   its word and item_stall rises once that register is also full.
module arming_sequence_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [1:0]                action,
  input  logic                      force_arm,
  input  logic                      pos_fix,
  input  logic [asc_pkg::TimeW-1:0] now_time,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      accepted,
  output logic [2:0]                event_code,
  output logic [2:0]                phase_now,
  input  logic                      cfg_wr_en,
  input  logic [asc_pkg::DurW-1:0]  cfg_wr_data
);
  import asc_pkg::*;

  item_t   item_in, held_item;
  logic    held_valid;
  logic    out_free;
  logic    step;
  result_t core_result, held_result;

  assign item_in.action     = action;
  assign item_in.force_arm  = force_arm;
  assign item_in.pos_fix    = pos_fix;
  assign item_in.now_time   = now_time;

  // held word moves into the result register whenever that register is free
  assign step = held_valid && out_free;

  asc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .advance    (out_free),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // state updates on the same edge the result is captured
  asc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (held_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (core_result)
  );

  asc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (held_valid),
    .load_result  (core_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .held_result  (held_result)
  );

  assign accepted   = held_result.accepted;
  assign event_code = held_result.event_code;
  assign phase_now  = held_result.phase_now;

endmodule

// ===== tb/sv/tb_arming_sequence_controller.sv =====
`timescale 1ns / 100ps
// Testbench for arming_sequence_controller: directed and random words checked
// against a scoreboard that tracks the arm/disarm phases. Depends on asc_pkg.

module tb_arming_sequence_controller;
  import asc_pkg::*;

  class arming_scoreboard;
    // predicted controller state and its copy of the duration register
    phase_t            phase;
    logic [TimeW-1:0]  deadline;
    logic              force_latched;
    logic [DurW-1:0]   duration;

    result_t           expected_results[$];
    int unsigned       words_noted;
    int unsigned       results_checked;
    int unsigned       mismatches;
    int unsigned       events_seen[5];

    function new();
      phase         = PH_DISARMED;
      deadline      = '0;
      force_latched = 1'b0;
      duration      = '0;
      words_noted   = 0;
      results_checked = 0;
      mismatches    = 0;
      foreach (events_seen[i]) events_seen[i] = 0;
    endfunction

    function void set_duration(logic [DurW-1:0] value);
      duration = value;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // one step tick against the predicted phase
    function event_t advance_phase(logic [TimeW-1:0] now, logic gps);
      logic [TimeW:0] sum;
      event_t         ev;
      ev = EV_NONE;
      case (phase)
        PH_DISARM_PENDING: begin
          phase    = PH_DISARMED;
          deadline = '0;
          ev       = EV_DISARM;
        end
        PH_ARM_PENDING: begin
          if (!force_latched && !gps) begin
            phase = PH_DISARMED;
            ev    = EV_REJECT;
          end else begin
            sum      = {1'b0, now} + {{(TimeW + 1 - DurW){1'b0}}, duration};
            // deadline saturates at the top of the time range
            deadline = sum[TimeW] ? '1 : sum[TimeW-1:0];
            phase    = PH_ARMING;
            ev       = EV_BEGIN;
          end
        end
        PH_ARMING: begin
          if (now >= deadline) begin
            phase    = PH_ARMED;
            deadline = '0;
            ev       = EV_COMPLETE;
          end
        end
        default: ;
      endcase
      return ev;
    endfunction

    function void note_word(logic [1:0] act, logic frc, logic gps, logic [TimeW-1:0] now);
      result_t r;
      r = '0;
      case (act)
        ACT_DISARM: begin
          phase         = PH_DISARM_PENDING;
          deadline      = '0;
          force_latched = 1'b0;
          r.accepted    = 1'b1;
        end
        ACT_ARM: begin
          if (phase == PH_DISARMED) begin
            phase         = PH_ARM_PENDING;
            force_latched = frc;
            r.accepted    = 1'b1;
          end
        end
        ACT_TICK: r.event_code = advance_phase(now, gps);
        default: ;  // unused code leaves the state alone
      endcase
      r.phase_now = phase;
      expected_results.push_back(r);
      words_noted++;
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH result %0d %s: expected %0d, got %0d",
                 results_checked, field, want, got);
    endfunction

    function void check_result(logic acc, logic [2:0] ev, logic [2:0] ph);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH result %0d arrived with nothing expected", results_checked);
        results_checked++;
        return;
      end
      want = expected_results.pop_front();
      if (acc !== want.accepted)   flag("accepted", want.accepted, acc);
      if (ev  !== want.event_code) flag("event_code", want.event_code, ev);
      if (ph  !== want.phase_now)  flag("phase_now", want.phase_now, ph);
      if (ev <= 3'd4) events_seen[ev]++;
      results_checked++;
    endfunction
  endclass

  localparam logic [1:0]       ACT_UNUSED  = 2'd3;        // action code with no meaning
  localparam logic [TimeW-1:0] TIME_MAX    = '1;
  localparam int unsigned      CYCLE_LIMIT = 200000;
  localparam int unsigned      WORDS_PER_PHASE = 250;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  logic [1:0]       action;
  logic             force_arm;
  logic             pos_fix;
  logic [TimeW-1:0] now_time;
  logic             result_valid;
  logic             result_stall;
  logic             accepted;
  logic [2:0]       event_code;
  logic [2:0]       phase_now;
  logic             cfg_wr_en;
  logic [DurW-1:0]  cfg_wr_data;

  arming_scoreboard board;

  int unsigned      send_idle_pct;   // chance of an idle cycle before each word
  int unsigned      stall_pct;       // chance the receiver stalls in a cycle
  int unsigned      hold_req;        // bumped by the stimulus to ask for a long hold
  int unsigned      hold_seen;
  int unsigned      hold_len;
  int unsigned      hold_left;
  int unsigned      holds_done;
  int unsigned      words_sent;      // words that the block acts on
  int unsigned      cycle_count;
  int unsigned      settings_used;
  logic [DurW-1:0]  duration_set;    // last written duration, steers tick times

  arming_sequence_controller dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .force_arm    (force_arm),
    .pos_fix      (pos_fix),
    .now_time     (now_time),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted),
    .event_code   (event_code),
    .phase_now    (phase_now),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("arming_sequence_controller verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus long holds requested by the stimulus. The
  // hold is counted here so the sender keeps offering words and the block
  // fills up behind the stalled output.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
      holds_done++;
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: both channels are sampled at the edge, before any NBA lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall)
        board.note_word(action, force_arm, pos_fix, now_time);
      if (result_valid && !result_stall)
        board.check_result(accepted, event_code, phase_now);
    end
  end

  function automatic logic rbit();
    return $urandom_range(0, 1) == 1;
  endfunction

  function automatic logic [TimeW-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TimeW-1:0];
  endfunction

  // Offer one word; returns at the edge that takes it. Valid is only lowered
  // for an idle gap, so back-to-back words keep it high.
  task automatic send_word(input logic [1:0] act, input logic frc, input logic gps,
                           input logic [TimeW-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    force_arm  <= frc;
    pos_fix    <= gps;
    now_time   <= now;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (act != ACT_UNUSED) words_sent++;
  endtask

  // Sender pauses until every expected result is back, then idles on as slack
  // for the two-stage pipe.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_duration(input logic [DurW-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.set_duration(value);
    duration_set = value;
    settings_used++;
  endtask

  // One well-formed pass: disarm, arm, begin, ticks toward the deadline,
  // with refused requests and stray ticks mixed in.
  task automatic run_arm_pass();
    logic [TimeW-1:0] t;
    logic [TimeW:0]   goal;
    logic [TimeW-1:0] target;
    case ($urandom_range(0, 9))
      0:       t = TIME_MAX - $urandom_range(0, 3);
      1:       t = TIME_MAX - {31'd0, duration_set} - 1 + $urandom_range(0, 2);
      2:       t = rand_time();
      default: t = {31'd0, $urandom};
    endcase
    send_word(ACT_DISARM, rbit(), rbit(), rand_time());
    if ($urandom_range(0, 99) < 75) send_word(ACT_TICK, rbit(), rbit(), rand_time());
    send_word(ACT_ARM, rbit(), rbit(), rand_time());
    if ($urandom_range(0, 99) < 15) send_word(ACT_ARM, rbit(), rbit(), rand_time());
    if ($urandom_range(0, 99) < 5)  send_word(ACT_DISARM, rbit(), rbit(), rand_time());
    send_word(ACT_TICK, rbit(), $urandom_range(0, 99) < 75, t);
    goal   = {1'b0, t} + {{(TimeW + 1 - DurW){1'b0}}, duration_set};
    target = goal[TimeW] ? TIME_MAX : goal[TimeW-1:0];
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: t = target;                            // hit the deadline exactly
        3:       t = target - 1;                        // one short of it
        4:       t = target + $urandom_range(1, 1000);  // past it
        5, 6:    t = t + $urandom_range(0, 50);
        7:       t = t;
        default: t = rand_time();
      endcase
      send_word(ACT_TICK, rbit(), rbit(), t);
    end
    if ($urandom_range(0, 99) < 20) send_word(ACT_ARM, rbit(), rbit(), rand_time());
    if ($urandom_range(0, 99) < 10) send_word(ACT_UNUSED, rbit(), rbit(), rand_time());
  endtask

  initial begin
    int unsigned idle_tab[5];
    int unsigned stall_tab[5];
    int unsigned phase_end;
    int unsigned next_pause;

    idle_tab  = '{0, 58, 0, 30, 0};
    stall_tab = '{0, 0, 58, 30, 0};
    board = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 0;
    hold_seen     = 0;
    hold_len      = 0;
    hold_left     = 0;
    holds_done    = 0;
    words_sent    = 0;
    cycle_count   = 0;
    settings_used = 0;
    duration_set  = '0;

    rst          <= 1'b1;
    item_valid   <= 1'b0;
    action       <= ACT_DISARM;
    force_arm    <= 1'b0;
    pos_fix      <= 1'b0;
    now_time     <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset duration of zero.
    send_word(ACT_TICK,   1'b0, 1'b0, '0);            // tick while disarmed
    send_word(ACT_ARM,    1'b0, 1'b0, TIME_MAX);      // arm without force
    send_word(ACT_ARM,    1'b1, 1'b1, '0);            // refused in arm pending
    send_word(ACT_TICK,   1'b1, 1'b0, 63'd50);        // no fix, no force: reject
    send_word(ACT_ARM,    1'b1, 1'b0, '0);            // forced arm
    send_word(ACT_TICK,   1'b0, 1'b0, 63'd100);       // begins without a fix
    send_word(ACT_TICK,   1'b0, 1'b1, 63'd99);        // just before the deadline
    send_word(ACT_TICK,   1'b0, 1'b0, 63'd100);       // completes on equality
    send_word(ACT_TICK,   1'b1, 1'b1, TIME_MAX);      // armed: nothing happens
    send_word(ACT_ARM,    1'b1, 1'b1, '0);            // refused while armed
    send_word(ACT_UNUSED, 1'b1, 1'b1, TIME_MAX);      // unused action ignored
    send_word(ACT_DISARM, 1'b1, 1'b1, TIME_MAX);
    send_word(ACT_ARM,    1'b0, 1'b1, '0);            // refused in disarm pending
    send_word(ACT_DISARM, 1'b0, 1'b0, '0);            // disarm taken again
    send_word(ACT_TICK,   1'b0, 1'b0, '0);            // disarm event
    send_word(ACT_ARM,    1'b0, 1'b1, '0);
    send_word(ACT_TICK,   1'b0, 1'b1, TIME_MAX);      // begin at the top of time
    send_word(ACT_TICK,   1'b0, 1'b0, TIME_MAX);      // complete
    // Largest duration: the deadline sum saturates.
    write_duration('1);
    send_word(ACT_DISARM, 1'b0, 1'b0, '0);
    send_word(ACT_TICK,   1'b0, 1'b0, '0);
    send_word(ACT_ARM,    1'b0, 1'b0, '0);
    send_word(ACT_TICK,   1'b0, 1'b1, TIME_MAX - 63'd5);
    send_word(ACT_TICK,   1'b0, 1'b1, TIME_MAX - 63'd1);  // still short of it
    send_word(ACT_DISARM, 1'b1, 1'b0, '0);            // disarm out of arming
    send_word(ACT_TICK,   1'b0, 1'b0, '0);

    // Random phases, each under its own duration and idling mix.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       write_duration('0);
        1:       write_duration($urandom_range(2, 40));
        2:       write_duration('1);
        3:       write_duration($urandom);
        default: write_duration($urandom_range(1, 30));
      endcase
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      phase_end     = words_sent + WORDS_PER_PHASE;
      next_pause    = words_sent + 60;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 99) < 85) begin
          run_arm_pass();
        end else begin
          repeat ($urandom_range(1, 4))
            send_word(2'($urandom_range(0, 3)), rbit(), rbit(), rand_time());
        end
        if (words_sent >= next_pause) begin
          next_pause = words_sent + 60;
          if (p == 4) begin
            // long output hold while words keep coming
            hold_len = $urandom_range(40, 120);
            hold_req++;
          end else if (p == 3) begin
            wait_idle();
          end
        end
      end
    end

    wait_idle();
    $display("covered %0d words over %0d duration settings, %0d long output holds",
             board.words_noted, settings_used, holds_done);
    $display("events: none %0d, disarm %0d, reject %0d, begin %0d, complete %0d",
             board.events_seen[0], board.events_seen[1], board.events_seen[2],
             board.events_seen[3], board.events_seen[4]);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("arming_sequence_controller verification clean");
    end else begin
      $display("arming_sequence_controller verification failed");
    end
    $finish;
  end

endmodule
